// ===== rtl/apm_pkg.sv =====
// Shared opcodes, status codes and field widths of the array max-priority queue.
package apm_pkg;

  // Field widths of one input item and one result item.
  localparam int unsigned KeyW    = 16;
  localparam int unsigned TagW    = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned FillW   = 4;

  // Opcodes carried on the input tuser.
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Status codes carried on the output tuser.
  localparam logic [StatusW-1:0] ST_DONE  = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd2;

endpackage

// ===== rtl/array_max_priority_queue.sv =====
// Bounded max-priority queue as an unsorted array, with one comparator and two memory ports.
//
// Each input transfer is a push (tuser 0) of a key and tag, or a pop (tuser 1) of the entry
// with the largest key, the earliest one on equal keys. Entries sit in arrival order in a
// single-port-write, single-port-read memory of CAPACITY slots. A push, a push that finds the
// queue full and a pop that finds it empty go through the result register to the output
// register. A pop of a queue holding N entries reads every entry once through one comparator,
// then moves each entry behind the largest one down a slot through the same memory ports
// (none when the largest entry is the last), then presents the result. The input accepts
// one item at a time; a finished result waits in an output register and the next item is
// taken while it waits. Every result carries the status on tuser and the popped key, tag
// and fill count on tdata.
module array_max_priority_queue
  import apm_pkg::*;
#(
  parameter int unsigned CAPACITY = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input item stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [15:0] key, [47:16] tag
  input  logic        s_axis_tuser,   // [0] opcode
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [15:0] out_key, [47:16] out_tag, [51:48] fill_count
  output logic [1:0]  m_axis_tuser    // [1:0] status
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);

  // Sequencer codes.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [CntW-1:0]    ptr_q, ptr_d;
  logic               pend_q, pend_d;
  logic [IdxW-1:0]    pidx_q, pidx_d;
  logic [IdxW-1:0]    best_q, best_d;
  logic [StatusW-1:0] res_status_q, res_status_d;
  logic [KeyW-1:0]    res_key_q, res_key_d;
  logic [TagW-1:0]    res_tag_q, res_tag_d;
  logic               mvalid_q, mvalid_d;
  logic [StatusW-1:0] m_status_q, m_status_d;
  logic [KeyW-1:0]    m_key_q, m_key_d;
  logic [TagW-1:0]    m_tag_q, m_tag_d;
  logic [FillW-1:0]   m_fill_q, m_fill_d;

  // Entry store and its registered read data.
  logic [KeyW-1:0]    key_mem [CAPACITY];
  logic [TagW-1:0]    tag_mem [CAPACITY];
  logic [KeyW-1:0]    rd_key_q;
  logic [TagW-1:0]    rd_tag_q;
  logic               we;
  logic [IdxW-1:0]    waddr;
  logic [KeyW-1:0]    wkey;
  logic [TagW-1:0]    wtag;
  logic [IdxW-1:0]    raddr;

  logic               s_xfer;
  logic               issue;
  logic               take_new;
  logic               last_hit;
  logic [IdxW-1:0]    new_best;
  logic [CntW-1:0]    count_m1;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_xfer        = s_axis_tvalid && s_axis_tready;

  assign count_m1 = count_q - CntW'(1);
  assign raddr    = ptr_q[IdxW-1:0];
  assign issue    = (ptr_q < count_q);
  // The comparator: the first entry always wins, later ones only with a strictly larger key.
  assign take_new = (pidx_q == '0) || (rd_key_q > res_key_q);
  assign new_best = take_new ? pidx_q : best_q;
  assign last_hit = pend_q && (CntW'(pidx_q) == count_m1);

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ptr_d        = ptr_q;
    pend_d       = pend_q;
    pidx_d       = pidx_q;
    best_d       = best_q;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    res_tag_d    = res_tag_q;
    mvalid_d     = mvalid_q;
    m_status_d   = m_status_q;
    m_key_d      = m_key_q;
    m_tag_d      = m_tag_q;
    m_fill_d     = m_fill_q;
    we           = 1'b0;
    waddr        = count_q[IdxW-1:0];
    wkey         = s_axis_tdata[15:0];
    wtag         = s_axis_tdata[47:16];

    if (mvalid_q && m_axis_tready) begin
      mvalid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_xfer) begin
          res_key_d    = '0;
          res_tag_d    = '0;
          res_status_d = ST_DONE;
          state_d      = S_DONE;
          if (s_axis_tuser == OP_PUSH) begin
            if (count_q == CntW'(CAPACITY)) begin
              res_status_d = ST_FULL;
            end else begin
              we      = 1'b1;
              count_d = count_q + CntW'(1);
            end
          end else if (count_q == '0) begin
            res_status_d = ST_EMPTY;
          end else begin
            ptr_d   = '0;
            pend_d  = 1'b0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Read one slot a cycle and compare it against the best so far.
        pend_d = issue;
        if (issue) begin
          ptr_d  = ptr_q + CntW'(1);
          pidx_d = ptr_q[IdxW-1:0];
        end
        if (pend_q && take_new) begin
          res_key_d = rd_key_q;
          res_tag_d = rd_tag_q;
          best_d    = pidx_q;
        end
        if (last_hit) begin
          if (CntW'(new_best) == count_m1) begin
            count_d = count_m1;
            state_d = S_DONE;
          end else begin
            ptr_d   = CntW'(new_best) + CntW'(1);
            pend_d  = 1'b0;
            state_d = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        // Read the slot behind and write it one place down on the next cycle.
        pend_d = issue;
        if (issue) begin
          ptr_d  = ptr_q + CntW'(1);
          pidx_d = ptr_q[IdxW-1:0];
        end
        if (pend_q) begin
          we    = 1'b1;
          waddr = pidx_q - IdxW'(1);
          wkey  = rd_key_q;
          wtag  = rd_tag_q;
        end
        if (last_hit) begin
          count_d = count_m1;
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // Hand the result to the output register once it is free.
        if (!mvalid_q || m_axis_tready) begin
          mvalid_d   = 1'b1;
          m_status_d = res_status_q;
          m_key_d    = res_key_q;
          m_tag_d    = res_tag_q;
          m_fill_d   = FillW'(count_q);
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ptr_q    <= '0;
      pend_q   <= 1'b0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ptr_q    <= ptr_d;
      pend_q   <= pend_d;
      mvalid_q <= mvalid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pidx_q       <= pidx_d;
    best_q       <= best_d;
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    res_tag_q    <= res_tag_d;
    m_status_q   <= m_status_d;
    m_key_q      <= m_key_d;
    m_tag_q      <= m_tag_d;
    m_fill_q     <= m_fill_d;
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      tag_mem[waddr] <= wtag;
    end
    rd_key_q <= key_mem[raddr];
    rd_tag_q <= tag_mem[raddr];
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {4'b0, m_fill_q, m_tag_q, m_key_q};

`ifndef SYNTHESIS
  // The fill count never goes past the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count exceeds capacity");

  // An accepted push into a queue with room grows the count by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && (s_axis_tuser == OP_PUSH) && (count_q < CntW'(CAPACITY))
    |=> count_q == $past(count_q) + CntW'(1))
    else $error("push did not grow the entry count");

  // A pop of a non-empty queue starts the scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && (s_axis_tuser == OP_POP) && (count_q != '0) |=> state_q == S_SCAN)
    else $error("pop did not start the scan");

  // Only a completed pop returns a key or a tag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mvalid_q && (m_status_q != ST_DONE) |-> (m_key_q == '0) && (m_tag_q == '0))
    else $error("rejected operation returned an entry");
`endif

endmodule

// ===== verif/array_max_priority_queue_tb.sv =====
// Self-checking testbench for the array max-priority queue, driven through its stream ports.
`timescale 1ns / 1ps

module array_max_priority_queue_tb;
  import apm_pkg::*;

  localparam int unsigned DEPTH        = 8;
  localparam int          RANDOM_ITEMS = 600;
  localparam int          LONG_HOLD    = 300;
  localparam int          END_WAIT     = 2 * DEPTH + 8;
  localparam int          CYCLE_LIMIT  = 200000;
  localparam int          NUM_ROWS     = 24;

  // One popped or rejected result as it leaves the block.
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [KeyW-1:0]    key;
    logic [TagW-1:0]    tag;
    logic [FillW-1:0]   fill;
  } pq_result_t;

  // One directed step; the result fields count only where known is set.
  typedef struct packed {
    logic               op;
    logic [KeyW-1:0]    key;
    logic [TagW-1:0]    tag;
    bit                 known;
    logic [StatusW-1:0] status;
    logic [KeyW-1:0]    out_key;
    logic [TagW-1:0]    out_tag;
    logic [FillW-1:0]   fill;
  } step_t;

  // Receiver behaviors, each held for a stretch of cycles.
  typedef enum int {
    SINK_OPEN,
    SINK_HALF,
    SINK_MOSTLY_OPEN,
    SINK_MOSTLY_SHUT
  } sink_mode_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata  = '0;  // [15:0] key, [47:16] tag
  logic        s_axis_tuser  = OP_PUSH;  // [0] opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;  // [15:0] out_key, [47:16] out_tag, [51:48] fill_count
  logic [1:0]  m_axis_tuser;  // [1:0] status

  // Shadow copy of the queue contents, in arrival order.
  logic [KeyW-1:0] held_keys [DEPTH];
  logic [TagW-1:0] held_tags [DEPTH];
  int unsigned     held_count = 0;

  pq_result_t pending [$];
  int         mismatches   = 0;
  int         results_seen = 0;
  int         cycle_count  = 0;
  int         burst_left   = 0;

  // Directed steps: empty pop, extremes, ties, overflow, drain, a second empty pop and a tied pair.
  step_t plan [NUM_ROWS] = '{
    '{OP_POP,  16'h0000, 32'h0000_0000, 1'b1, ST_EMPTY, 16'h0000, 32'h0000_0000, 4'd0},
    '{OP_PUSH, 16'h0000, 32'h0000_0000, 1'b1, ST_DONE,  16'h0000, 32'h0000_0000, 4'd1},
    '{OP_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_DONE,  16'h0000, 32'h0000_0000, 4'd2},
    '{OP_PUSH, 16'h1234, 32'h0000_00A1, 1'b0, ST_DONE,  16'h0000, 32'h0000_0000, 4'd0},
    '{OP_PUSH, 16'hFFFF, 32'h0000_0001, 1'b0, ST_DONE,  16'h0000, 32'h0000_0000, 4'd0},
    '{OP_PUSH, 16'h0001, 32'h5555_5555, 1'b0, ST_DONE,  16'h0000, 32'h0000_0000, 4'd0},
    '{OP_PUSH, 16'h8000, 32'hAAAA_AAAA, 1'b0, ST_DONE,  16'h0000, 32'h0000_0000, 4'd0},
    '{OP_PUSH, 16'h7FFF, 32'h8000_0000, 1'b0, ST_DONE,  16'h0000, 32'h0000_0000, 4'd0},
    '{OP_PUSH, 16'hFFFF, 32'h0000_0002, 1'b1, ST_DONE,  16'h0000, 32'h0000_0000, 4'd8},
    '{OP_PUSH, 16'hAAAA, 32'h1357_9BDF, 1'b1, ST_FULL,  16'h0000, 32'h0000_0000, 4'd8},
    '{OP_PUSH, 16'h5555, 32'h2468_ACE0, 1'b1, ST_FULL,  16'h0000, 32'h0000_0000, 4'd8},
    '{OP_POP,  16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_DONE,  16'hFFFF, 32'hFFFF_FFFF, 4'd7},
    '{OP_POP,  16'h0000, 32'h0000_0000, 1'b1, ST_DONE,  16'hFFFF, 32'h0000_0001, 4'd6},
    '{OP_POP,  16'h0000, 32'h0000_0000, 1'b0, ST_DONE,  16'h0000, 32'h0000_0000, 4'd0},
    '{OP_POP,  16'h5555, 32'h5555_5555, 1'b0, ST_DONE,  16'h0000, 32'h0000_0000, 4'd0},
    '{OP_POP,  16'hAAAA, 32'hAAAA_AAAA, 1'b0, ST_DONE,  16'h0000, 32'h0000_0000, 4'd0},
    '{OP_POP,  16'h0000, 32'h0000_0000, 1'b0, ST_DONE,  16'h0000, 32'h0000_0000, 4'd0},
    '{OP_POP,  16'h0000, 32'h0000_0000, 1'b0, ST_DONE,  16'h0000, 32'h0000_0000, 4'd0},
    '{OP_POP,  16'h0000, 32'h0000_0000, 1'b0, ST_DONE,  16'h0000, 32'h0000_0000, 4'd0},
    '{OP_POP,  16'h0000, 32'h0000_0000, 1'b1, ST_EMPTY, 16'h0000, 32'h0000_0000, 4'd0},
    '{OP_PUSH, 16'h5555, 32'h5555_5555, 1'b0, ST_DONE,  16'h0000, 32'h0000_0000, 4'd0},
    '{OP_PUSH, 16'h5555, 32'hAAAA_AAAA, 1'b0, ST_DONE,  16'h0000, 32'h0000_0000, 4'd0},
    '{OP_POP,  16'h0000, 32'h0000_0000, 1'b0, ST_DONE,  16'h0000, 32'h0000_0000, 4'd0},
    '{OP_POP,  16'h0000, 32'h0000_0000, 1'b0, ST_DONE,  16'h0000, 32'h0000_0000, 4'd0}
  };

  array_max_priority_queue #(
    .CAPACITY(DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Free-running clock, 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Applies one operation to the shadow queue and returns the result it should produce.
  function automatic pq_result_t queue_apply(logic op, logic [KeyW-1:0] key,
                                             logic [TagW-1:0] tag);
    pq_result_t  r;
    int unsigned best;
    r = '0;
    r.status = ST_DONE;
    if (op == OP_PUSH) begin
      if (held_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        held_keys[held_count] = key;
        held_tags[held_count] = tag;
        held_count++;
      end
    end else if (held_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      // Strictly greater keeps the earliest entry on equal keys.
      best = 0;
      for (int unsigned i = 1; i < held_count; i++) begin
        if (held_keys[i] > held_keys[best]) best = i;
      end
      r.key = held_keys[best];
      r.tag = held_tags[best];
      for (int unsigned i = best; i + 1 < held_count; i++) begin
        held_keys[i] = held_keys[i + 1];
        held_tags[i] = held_tags[i + 1];
      end
      held_count--;
    end
    r.fill = FillW'(held_count);
    return r;
  endfunction

  // Offers one item and returns once the transfer has taken place.
  task automatic offer_item(input logic op, input logic [KeyW-1:0] key,
                            input logic [TagW-1:0] tag, output pq_result_t predicted);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {tag, key};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = queue_apply(op, key, tag);
  endtask

  // Sender bursts: after each burst, a random gap with valid low.
  task automatic pace_sender();
    burst_left--;
    if (burst_left <= 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // Holds the sender off until every expected result has been seen.
  task automatic settle_queue();
    s_axis_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Stimulus: directed steps first, then random segments of varying push ratio.
  initial begin : stimulus
    step_t           row;
    pq_result_t      predicted;
    int              push_pct;
    int              seg_left;
    logic            op;
    logic [KeyW-1:0] key;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst_left = $urandom_range(1, 24);

    for (int n = 0; n < NUM_ROWS; n++) begin
      row = plan[n];
      offer_item(row.op, row.key, row.tag, predicted);
      if (row.known) begin
        pending.push_back('{row.status, row.out_key, row.out_tag, row.fill});
      end else begin
        pending.push_back(predicted);
      end
      pace_sender();
    end
    settle_queue();

    seg_left = 0;
    push_pct = 50;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Segments lean toward filling, draining or balance, so full and empty both recur.
      if (seg_left == 0) begin
        case ($urandom_range(0, 3))
          0:       push_pct = 85;
          1:       push_pct = 15;
          2:       push_pct = 50;
          default: push_pct = 65;
        endcase
        seg_left = $urandom_range(10, 60);
      end
      seg_left--;
      op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
      // Narrow keys make ties common; the rest are extremes or spread over the range.
      case ($urandom_range(0, 9))
        0, 1, 2, 3: key = KeyW'($urandom_range(0, 7));
        4:          key = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        default:    key = KeyW'($urandom_range(0, 65535));
      endcase
      offer_item(op, key, $urandom(), predicted);
      pending.push_back(predicted);
      if (n == RANDOM_ITEMS / 2) begin
        settle_queue();
      end else begin
        pace_sender();
      end
    end

    // Let the last results drain, then watch a little longer for stray ones.
    settle_queue();
    repeat (END_WAIT) @(posedge clk_i);
    if (mismatches == 0 && pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Receiver: stretches of differing readiness, plus one long hold-off to back up the input.
  initial begin : result_sink
    bit         held;
    int         span;
    sink_mode_e mode;
    held = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held && results_seen >= 150) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      span = $urandom_range(8, 48);
      mode = sink_mode_e'($urandom_range(0, 3));
      repeat (span) begin
        case (mode)
          SINK_OPEN:        m_axis_tready <= 1'b1;
          SINK_HALF:        m_axis_tready <= ($urandom_range(0, 1) == 1);
          SINK_MOSTLY_OPEN: m_axis_tready <= ($urandom_range(0, 3) != 0);
          default:          m_axis_tready <= ($urandom_range(0, 4) == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    pq_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending.size() == 0) begin
        $error("unexpected result: status %0d, tdata %h", m_axis_tuser, m_axis_tdata);
        mismatches++;
      end else begin
        want = pending.pop_front();
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[15:0] !== want.key) begin
          $error("out_key: expected %h, got %h", want.key, m_axis_tdata[15:0]);
          mismatches++;
        end
        if (m_axis_tdata[47:16] !== want.tag) begin
          $error("out_tag: expected %h, got %h", want.tag, m_axis_tdata[47:16]);
          mismatches++;
        end
        if (m_axis_tdata[51:48] !== want.fill) begin
          $error("fill_count: expected %0d, got %0d", want.fill, m_axis_tdata[51:48]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
rtl/apm_pkg.sv
rtl/array_max_priority_queue.sv
verif/array_max_priority_queue_tb.sv
